// ----- design/eddist_pkg.sv -----
package eddist_pkg;

  // longest string that is kept
  localparam int unsigned MAX_LEN = 32;

  // width of a length or of a table entry, and of a text or row index
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // result field widths
  localparam int unsigned DIST_W = 7;
  localparam int unsigned CHAR_W = 8;

  // answer given when a string got too long
  localparam logic [DIST_W-1:0] TOO_LONG_DISTANCE = DIST_W'(99);

  // bit forced to one before two characters are compared
  localparam logic [CHAR_W-1:0] FOLD_MASK = CHAR_W'(32);

  typedef enum logic [1:0] {
    ACT_APPEND_FIRST  = 2'd0,
    ACT_APPEND_SECOND = 2'd1,
    ACT_COMPUTE       = 2'd2,
    ACT_UNUSED        = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_CALC = 2'b10
  } state_e;

endpackage

// ----- design/edit_distance_engine_top.sv -----
// edit distance engine: case-folding Levenshtein distance of two byte strings
//
// input channel (in_valid_i / in_ready_o) carries one beat per action:
//   append a character to the first or second string, or compute.
// output channel (out_valid_o / out_ready_i) carries one beat per compute:
//   distance and too_long. Appends and the unused action give no beat.
// a compute beat walks the distance table one cell per cycle through a
// single min-of-three cell unit, covering all la * lb cells (la, lb: stored
// lengths) before its result is registered; when a string is empty or too
// long the result is registered in the cycle of acceptance. The table keeps
// one row of MAX_LEN entries in flip-flops, read and written at the current
// column in each cycle of the walk.
// the result sits in an output register: appends are still taken while it
// waits, a compute beat is held off until the output register is free.
// reset empties both strings, clears the too-long flags and drops any
// pending result; stored characters and the row need no reset.
module edit_distance_engine_top import eddist_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [CHAR_W-1:0] char_code_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DIST_W-1:0] distance_o,
  output logic              too_long_o
);

  // string storage and lengths
  logic [CHAR_W-1:0] first_text_q  [MAX_LEN];
  logic [CHAR_W-1:0] second_text_q [MAX_LEN];
  logic [LEN_W-1:0]  first_len_q, first_len_d;
  logic [LEN_W-1:0]  second_len_q, second_len_d;
  logic              first_over_q, first_over_d;
  logic              second_over_q, second_over_d;

  // working row: entry k holds column k+1
  logic [LEN_W-1:0]  row_q [MAX_LEN];

  // sequencer
  state_e            state_q, state_d;
  logic [LEN_W-1:0]  i_q, i_d;
  logic [LEN_W-1:0]  j_q, j_d;
  logic [LEN_W-1:0]  diag_q, diag_d;
  logic [LEN_W-1:0]  left_q, left_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [DIST_W-1:0] distance_q, distance_d;
  logic              too_long_q, too_long_d;

  logic              out_free;
  logic              in_fire;
  logic              row_we;
  action_e           action;

  logic [LEN_W-1:0]  i_m1, j_m1;
  logic [IDX_W-1:0]  ca_idx, cb_idx, first_wr_idx, second_wr_idx;
  logic [CHAR_W-1:0] ca, cb;
  logic              cost;
  logic [LEN_W-1:0]  up;
  logic [LEN_W:0]    up_p1, left_p1, diag_pc, best_w;
  logic [LEN_W-1:0]  best;

  assign action   = action_e'(action_i);
  assign out_free = !out_valid_q || out_ready_i;

  // compute waits for a free output register, appends only for idle
  always_comb begin
    in_ready_o = 1'b0;
    if (state_q == ST_IDLE) begin
      in_ready_o = (action != ACT_COMPUTE) || out_free;
    end
  end

  assign in_fire = in_valid_i && in_ready_o;

  // cell unit: one table cell per cycle
  assign i_m1   = i_q - LEN_W'(1);
  assign j_m1   = j_q - LEN_W'(1);
  assign ca_idx = i_m1[IDX_W-1:0];
  assign cb_idx = j_m1[IDX_W-1:0];
  assign ca     = first_text_q[ca_idx] | FOLD_MASK;
  assign cb     = second_text_q[cb_idx] | FOLD_MASK;
  assign cost   = (ca != cb);
  assign up     = (i_q == LEN_W'(1)) ? j_q : row_q[cb_idx];

  always_comb begin
    up_p1   = {1'b0, up} + (LEN_W+1)'(1);
    left_p1 = {1'b0, left_q} + (LEN_W+1)'(1);
    diag_pc = {1'b0, diag_q} + (LEN_W+1)'(cost);
    best_w  = up_p1;
    if (left_p1 < best_w) begin
      best_w = left_p1;
    end
    if (diag_pc < best_w) begin
      best_w = diag_pc;
    end
    best = best_w[LEN_W-1:0];
  end

  assign first_wr_idx  = first_len_q[IDX_W-1:0];
  assign second_wr_idx = second_len_q[IDX_W-1:0];

  // sequencer and output control
  always_comb begin
    state_d       = state_q;
    i_d           = i_q;
    j_d           = j_q;
    diag_d        = diag_q;
    left_d        = left_q;
    first_len_d   = first_len_q;
    second_len_d  = second_len_q;
    first_over_d  = first_over_q;
    second_over_d = second_over_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    distance_d    = distance_q;
    too_long_d    = too_long_q;
    row_we        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (action)
            ACT_APPEND_FIRST: begin
              if (first_len_q < LEN_W'(MAX_LEN)) begin
                first_len_d = first_len_q + LEN_W'(1);
              end else begin
                first_over_d = 1'b1;
              end
            end
            ACT_APPEND_SECOND: begin
              if (second_len_q < LEN_W'(MAX_LEN)) begin
                second_len_d = second_len_q + LEN_W'(1);
              end else begin
                second_over_d = 1'b1;
              end
            end
            ACT_COMPUTE: begin
              if (first_over_q || second_over_q) begin
                out_valid_d = 1'b1;
                distance_d  = TOO_LONG_DISTANCE;
                too_long_d  = 1'b1;
              end else if (first_len_q == '0) begin
                out_valid_d = 1'b1;
                distance_d  = DIST_W'(second_len_q);
                too_long_d  = 1'b0;
              end else if (second_len_q == '0) begin
                out_valid_d = 1'b1;
                distance_d  = DIST_W'(first_len_q);
                too_long_d  = 1'b0;
              end
              if (first_over_q || second_over_q ||
                  first_len_q == '0 || second_len_q == '0) begin
                first_len_d   = '0;
                second_len_d  = '0;
                first_over_d  = 1'b0;
                second_over_d = 1'b0;
              end else begin
                state_d = ST_CALC;
                i_d     = LEN_W'(1);
                j_d     = LEN_W'(1);
                diag_d  = '0;
                left_d  = LEN_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CALC: begin
        row_we = 1'b1;
        if (j_q == second_len_q) begin
          if (i_q == first_len_q) begin
            // last cell: register the answer and empty both strings
            state_d      = ST_IDLE;
            out_valid_d  = 1'b1;
            distance_d   = DIST_W'(best);
            too_long_d   = 1'b0;
            first_len_d  = '0;
            second_len_d = '0;
          end else begin
            i_d    = i_q + LEN_W'(1);
            j_d    = LEN_W'(1);
            diag_d = i_q;
            left_d = i_q + LEN_W'(1);
          end
        end else begin
          j_d    = j_q + LEN_W'(1);
          diag_d = up;
          left_d = best;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      first_len_q   <= '0;
      second_len_q  <= '0;
      first_over_q  <= 1'b0;
      second_over_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      first_len_q   <= first_len_d;
      second_len_q  <= second_len_d;
      first_over_q  <= first_over_d;
      second_over_q <= second_over_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    diag_q     <= diag_d;
    left_q     <= left_d;
    distance_q <= distance_d;
    too_long_q <= too_long_d;
  end

  // string storage writes
  always_ff @(posedge clk_i) begin
    if (in_fire && action == ACT_APPEND_FIRST && first_len_q < LEN_W'(MAX_LEN)) begin
      first_text_q[first_wr_idx] <= char_code_i;
    end
    if (in_fire && action == ACT_APPEND_SECOND && second_len_q < LEN_W'(MAX_LEN)) begin
      second_text_q[second_wr_idx] <= char_code_i;
    end
  end

  // row update at the current column
  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_q[cb_idx] <= best;
    end
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = distance_q;
  assign too_long_o  = too_long_q;

endmodule
